>>> design/triangle_raster_depth_test_defines.svh
// Assertion macros for the checker file of the rasterizer.
`ifndef TRIANGLE_RASTER_DEPTH_TEST_DEFINES_SVH
`define TRIANGLE_RASTER_DEPTH_TEST_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define TRD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rasterizer check failed");

// Next-cycle implication, masked during reset.
`define TRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rasterizer check failed");

// Next-cycle implication that also covers reset itself.
`define TRD_ASSERT_RST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rasterizer reset check failed");

`endif

>>> design/trd_pkg.sv
// Shared constants, codes and types of the triangle rasterizer.
`timescale 1ns / 1ps
package trd_pkg;

  localparam int EXTENT  = 64;
  localparam int PIXELS  = EXTENT * EXTENT;
  localparam int ADDR_W  = $clog2(PIXELS);
  localparam int PIX_W   = $clog2(EXTENT);

  localparam int COORD_W = 18;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int DEPTH_W = 16;
  localparam int COLOR_W = 32;
  localparam int COUNT_W = 13;
  localparam int IDX_W   = 12;
  localparam int FRAC_W  = 8;
  localparam logic [FRAC_W-1:0] HALF_PIX = 8'h80;

  localparam int W_W       = 2 * DIFF_W + 1;   // edge value / area
  localparam int PROD_W    = W_W + DIFF_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int QUOT_BITS = DEPTH_W + 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_DRAW  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  typedef enum logic [1:0] {
    MAC_NOP  = 2'd0,
    MAC_LOAD = 2'd1,
    MAC_ADD  = 2'd2,
    MAC_SUB  = 2'd3
  } mac_op_t;

  typedef struct packed {
    mac_op_t                  op;
    logic signed [W_W-1:0]    a;
    logic signed [DIFF_W-1:0] b;
  } mac_req_t;

  typedef struct packed {
    logic                      en;
    logic [ADDR_W-1:0]         addr;
    logic signed [DEPTH_W-1:0] depth;
    logic [COLOR_W-1:0]        color;
  } fb_wr_t;

endpackage

>>> design/trd_mac.sv
// Shared multiply-accumulate unit: operand register, product register, accumulator.
`timescale 1ns / 1ps
module trd_mac (
  input  logic                              clk,
  input  logic                              rst,
  input  trd_pkg::mac_req_t                 req,
  output logic signed [trd_pkg::ACC_W-1:0]  acc
);
  import trd_pkg::*;

  logic signed [W_W-1:0]    a_r;
  logic signed [DIFF_W-1:0] b_r;
  mac_op_t                  op0;
  mac_op_t                  op1;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext;

  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      op0 <= MAC_NOP;
      op1 <= MAC_NOP;
    end else begin
      op0 <= req.op;
      op1 <= op0;
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= req.a;
    b_r  <= req.b;
    prod <= a_r * b_r;
    case (op1)
      MAC_LOAD: acc <= prod_ext;
      MAC_ADD:  acc <= acc + prod_ext;
      MAC_SUB:  acc <= acc - prod_ext;
      default:  acc <= acc;
    endcase
  end

endmodule

>>> design/trd_div.sv
// Restoring divider, one quotient bit per cycle, quotient truncated toward zero.
`timescale 1ns / 1ps
module trd_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [trd_pkg::ACC_W-1:0]    num,
  input  logic signed [trd_pkg::W_W-1:0]      den,
  output logic                                done,
  output logic signed [trd_pkg::DEPTH_W-1:0]  quot
);
  import trd_pkg::*;

  localparam int CNT_W = $clog2(QUOT_BITS);

  logic [ACC_W-1:0]     rem;
  logic [ACC_W-1:0]     dsr;
  logic [QUOT_BITS-1:0] q;
  logic [CNT_W-1:0]     cnt;
  logic                 neg;
  logic                 run;
  logic [ACC_W-1:0]     num_mag;
  logic [ACC_W-1:0]     den_mag;
  logic                 fits;

  assign num_mag = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
  assign den_mag = den[W_W-1] ? ACC_W'(-den) : ACC_W'(den);
  assign fits    = rem >= dsr;
  assign quot    = neg ? DEPTH_W'(-q) : DEPTH_W'(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == CNT_W'(QUOT_BITS - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num_mag;
      dsr <= den_mag << (QUOT_BITS - 1);
      q   <= '0;
      cnt <= '0;
      neg <= num[ACC_W-1] ^ den[W_W-1];
    end else if (run) begin
      if (fits) rem <= rem - dsr;
      q   <= {q[QUOT_BITS-2:0], fits};
      dsr <= dsr >> 1;
      cnt <= cnt + 1'b1;
    end
  end

endmodule

>>> design/trd_frame.sv
// Depth and color stores: one write port, one registered read port.
`timescale 1ns / 1ps
module trd_frame (
  input  logic                                clk,
  input  trd_pkg::fb_wr_t                     wr,
  input  logic [trd_pkg::ADDR_W-1:0]          raddr,
  output logic signed [trd_pkg::DEPTH_W-1:0]  rdepth,
  output logic [trd_pkg::COLOR_W-1:0]         rcolor
);
  import trd_pkg::*;

  logic signed [DEPTH_W-1:0] depth_mem [PIXELS];
  logic [COLOR_W-1:0]        color_mem [PIXELS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      depth_mem[wr.addr] <= wr.depth;
      color_mem[wr.addr] <= wr.color;
    end
    rdepth <= depth_mem[raddr];
    rcolor <= color_mem[raddr];
  end

endmodule

>>> design/triangle_raster_depth_test.sv
// Top level of the triangle rasterizer with depth test over an EXTENT x EXTENT image.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+------------------------------------------------
//  command   | start & !busy         | cmd, vert0..2 x/y/depth, tri_color, pixel_index
//  result    | done (one cycle)      | pixel_color, pixel_depth, written_count, degenerate
//
// A clear beat writes one store entry per cycle.
// Draw: area setup, then the edge and depth sums for each bounding-box pixel on the
// shared multiplier, plus the divider and the store write for each covered pixel.
// After reset the block runs a clearing pass over all PIXELS store entries with busy high.
// busy is high through all work; results are strobed once and cannot be held off.
`timescale 1ns / 1ps
module triangle_raster_depth_test (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  output logic                                   done,
  input  logic [1:0]                             cmd,
  input  logic signed [trd_pkg::COORD_W-1:0]     vert0_x,
  input  logic signed [trd_pkg::COORD_W-1:0]     vert0_y,
  input  logic signed [trd_pkg::DEPTH_W-1:0]     vert0_depth,
  input  logic signed [trd_pkg::COORD_W-1:0]     vert1_x,
  input  logic signed [trd_pkg::COORD_W-1:0]     vert1_y,
  input  logic signed [trd_pkg::DEPTH_W-1:0]     vert1_depth,
  input  logic signed [trd_pkg::COORD_W-1:0]     vert2_x,
  input  logic signed [trd_pkg::COORD_W-1:0]     vert2_y,
  input  logic signed [trd_pkg::DEPTH_W-1:0]     vert2_depth,
  input  logic [trd_pkg::COLOR_W-1:0]            tri_color,
  input  logic [trd_pkg::IDX_W-1:0]              pixel_index,
  output logic [trd_pkg::COLOR_W-1:0]            pixel_color,
  output logic signed [trd_pkg::DEPTH_W-1:0]     pixel_depth,
  output logic [trd_pkg::COUNT_W-1:0]            written_count,
  output logic                                   degenerate
);
  import trd_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_SETUP = 9'b000000100,
    S_BOX   = 9'b000001000,
    S_PIX   = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_WRITE = 9'b001000000,
    S_READ  = 9'b010000000,
    S_RDATA = 9'b100000000
  } state_t;

  // Sequencer steps: edge products issue at 0..5, depth products at 7..9.
  localparam logic [3:0] STEP_W0  = 4'd4;
  localparam logic [3:0] STEP_W1  = 4'd6;
  localparam logic [3:0] STEP_W2  = 4'd8;
  localparam logic [3:0] STEP_SUM = 4'd12;

  state_t state;
  logic [3:0] step;
  logic [ADDR_W-1:0] clr_addr;
  logic clr_reply;

  // Latched command.
  logic signed [COORD_W-1:0] vx0, vy0, vx1, vy1, vx2, vy2;
  logic signed [DEPTH_W-1:0] vd0, vd1, vd2;
  logic [COLOR_W-1:0]        color_r;
  logic [IDX_W-1:0]          idx_r;
  logic signed [DIFF_W-1:0]  dx12, dy12, dx20, dy20, dx01, dy01;

  logic signed [W_W-1:0] w0, w1, w2, area;
  logic [PIX_W-1:0] px, py, bx0, bx1, by1;
  logic [ADDR_W-1:0] row_base;
  logic [COUNT_W-1:0] count;

  mac_req_t mac_req;
  logic signed [ACC_W-1:0] acc;
  logic div_start, div_done;
  logic signed [DEPTH_W-1:0] z;
  fb_wr_t wr;
  logic [ADDR_W-1:0] raddr, cur_idx;
  logic signed [DEPTH_W-1:0] rdepth;
  logic [COLOR_W-1:0] rcolor;

  logic accept;
  logic signed [DIFF_W-1:0] pt_x, pt_y, ox1, oy1, ox2, oy2, ox0, oy0;
  logic covered;
  logic last_px, last_py;
  logic [PIX_W-1:0] bx0_c, bx1_c, by0_c, by1_c;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  function automatic logic signed [DIFF_W-1:0] sx(input logic signed [COORD_W-1:0] v);
    return {v[COORD_W-1], v};
  endfunction

  function automatic logic signed [W_W-1:0] wx(input logic signed [DIFF_W-1:0] v);
    return {{(W_W-DIFF_W){v[DIFF_W-1]}}, v};
  endfunction

  function automatic logic signed [DIFF_W-1:0] dx(input logic signed [DEPTH_W-1:0] v);
    return {{(DIFF_W-DEPTH_W){v[DEPTH_W-1]}}, v};
  endfunction

  // Pixel index from a floored/ceiled coordinate, clamped to the image.
  function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [10:0] v);
    logic [PIX_W-1:0] r;
    if (v < 11'sd0) r = '0;
    else if (v > $signed(11'(EXTENT - 1))) r = PIX_W'(EXTENT - 1);
    else r = PIX_W'(v);
    return r;
  endfunction

  // Bounding box from the latched vertices.
  always_comb begin
    logic signed [COORD_W-1:0] mnx, mxx, mny, mxy;
    logic signed [DIFF_W-1:0]  cxe, cye;
    mnx = (vx0 < vx1) ? vx0 : vx1;
    mnx = (mnx < vx2) ? mnx : vx2;
    mxx = (vx0 > vx1) ? vx0 : vx1;
    mxx = (mxx > vx2) ? mxx : vx2;
    mny = (vy0 < vy1) ? vy0 : vy1;
    mny = (mny < vy2) ? mny : vy2;
    mxy = (vy0 > vy1) ? vy0 : vy1;
    mxy = (mxy > vy2) ? mxy : vy2;
    cxe = sx(mxx) + DIFF_W'(255);
    cye = sx(mxy) + DIFF_W'(255);
    bx0_c = clamp_pix(11'(mnx >>> FRAC_W));
    by0_c = clamp_pix(11'(mny >>> FRAC_W));
    bx1_c = clamp_pix(11'(cxe >>> FRAC_W));
    by1_c = clamp_pix(11'(cye >>> FRAC_W));
  end

  // Evaluation point: vertex 2 during area setup, pixel center otherwise.
  always_comb begin
    if (state == S_SETUP) begin
      pt_x = sx(vx2);
      pt_y = sx(vy2);
    end else begin
      pt_x = $signed({{(DIFF_W-PIX_W-FRAC_W){1'b0}}, px, HALF_PIX});
      pt_y = $signed({{(DIFF_W-PIX_W-FRAC_W){1'b0}}, py, HALF_PIX});
    end
    ox0 = pt_x - sx(vx0);
    oy0 = pt_y - sx(vy0);
    ox1 = pt_x - sx(vx1);
    oy1 = pt_y - sx(vy1);
    ox2 = pt_x - sx(vx2);
    oy2 = pt_y - sx(vy2);
  end

  // Microcode for the shared multiplier.
  always_comb begin
    mac_req.op = MAC_NOP;
    mac_req.a  = wx(ox1);
    mac_req.b  = dy12;
    if (state == S_SETUP || state == S_PIX) begin
      case (step)
        4'd0: begin mac_req.op = MAC_LOAD; mac_req.a = wx(ox1); mac_req.b = dy12; end
        4'd1: begin mac_req.op = MAC_SUB;  mac_req.a = wx(oy1); mac_req.b = dx12; end
        4'd2: begin mac_req.op = MAC_LOAD; mac_req.a = wx(ox2); mac_req.b = dy20; end
        4'd3: begin mac_req.op = MAC_SUB;  mac_req.a = wx(oy2); mac_req.b = dx20; end
        4'd4: begin mac_req.op = MAC_LOAD; mac_req.a = wx(ox0); mac_req.b = dy01; end
        4'd5: begin mac_req.op = MAC_SUB;  mac_req.a = wx(oy0); mac_req.b = dx01; end
        4'd7: begin mac_req.op = MAC_LOAD; mac_req.a = w0; mac_req.b = dx(vd0); end
        4'd8: begin mac_req.op = MAC_ADD;  mac_req.a = w1; mac_req.b = dx(vd1); end
        4'd9: begin mac_req.op = MAC_ADD;  mac_req.a = w2; mac_req.b = dx(vd2); end
        default: mac_req.op = MAC_NOP;
      endcase
    end
  end

  // Inclusive edges; the sign of the area picks the winding.
  always_comb begin
    if (!area[W_W-1])
      covered = !w0[W_W-1] && !w1[W_W-1] && !w2[W_W-1];
    else
      covered = (w0[W_W-1] || w0 == '0) && (w1[W_W-1] || w1 == '0)
             && (w2[W_W-1] || w2 == '0);
  end

  assign last_px   = (px == bx1);
  assign last_py   = (py == by1);
  assign cur_idx   = row_base + ADDR_W'(px);
  assign raddr     = (state == S_READ) ? ADDR_W'(idx_r) : cur_idx;
  assign div_start = (state == S_PIX) && (step == STEP_SUM) && covered;

  always_comb begin
    wr.en    = 1'b0;
    wr.addr  = cur_idx;
    wr.depth = z;
    wr.color = color_r;
    if (state == S_CLEAR) begin
      wr.en    = 1'b1;
      wr.addr  = clr_addr;
      wr.depth = DEPTH_MIN;
      wr.color = '0;
    end else if (state == S_WRITE) begin
      wr.en = (z >= rdepth);
    end
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      step          <= '0;
      clr_addr      <= '0;
      clr_reply     <= 1'b0;
      done          <= 1'b0;
      pixel_color   <= '0;
      pixel_depth   <= '0;
      written_count <= '0;
      degenerate    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(PIXELS - 1)) begin
            state <= S_IDLE;
            if (clr_reply) begin
              done          <= 1'b1;
              pixel_color   <= '0;
              pixel_depth   <= '0;
              written_count <= '0;
              degenerate    <= 1'b0;
            end
          end
        end
        S_IDLE: begin
          if (accept) begin
            step <= '0;
            case (cmd)
              CMD_CLEAR: begin
                state     <= S_CLEAR;
                clr_addr  <= '0;
                clr_reply <= 1'b1;
              end
              CMD_DRAW: state <= S_SETUP;
              CMD_READ: state <= S_READ;
              default: begin
                done          <= 1'b1;
                pixel_color   <= '0;
                pixel_depth   <= '0;
                written_count <= '0;
                degenerate    <= 1'b0;
              end
            endcase
          end
        end
        S_SETUP: begin
          step <= step + 1'b1;
          if (step == STEP_W2) state <= S_BOX;
        end
        S_BOX: begin
          step <= '0;
          if (area == '0) begin
            state         <= S_IDLE;
            done          <= 1'b1;
            pixel_color   <= '0;
            pixel_depth   <= '0;
            written_count <= '0;
            degenerate    <= 1'b1;
          end else begin
            state <= S_PIX;
          end
        end
        S_PIX: begin
          step <= step + 1'b1;
          if (step == STEP_SUM) begin
            step <= '0;
            if (covered) state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) state <= S_WRITE;
        end
        S_WRITE: begin
          state <= S_PIX;
        end
        S_READ: begin
          state <= S_RDATA;
        end
        S_RDATA: begin
          state         <= S_IDLE;
          done          <= 1'b1;
          written_count <= '0;
          degenerate    <= 1'b0;
          if (32'(idx_r) < PIXELS) begin
            pixel_color <= rcolor;
            pixel_depth <= rdepth;
          end else begin
            pixel_color <= '0;
            pixel_depth <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase

      // Pixel walk and end of draw.
      if ((state == S_PIX && step == STEP_SUM && !covered) || state == S_WRITE) begin
        if (last_px && last_py) begin
          state         <= S_IDLE;
          done          <= 1'b1;
          pixel_color   <= '0;
          pixel_depth   <= '0;
          written_count <= (wr.en && count != COUNT_MAX) ? count + 1'b1 : count;
          degenerate    <= 1'b0;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      vx0 <= vert0_x;  vy0 <= vert0_y;  vd0 <= vert0_depth;
      vx1 <= vert1_x;  vy1 <= vert1_y;  vd1 <= vert1_depth;
      vx2 <= vert2_x;  vy2 <= vert2_y;  vd2 <= vert2_depth;
      color_r <= tri_color;
      idx_r   <= pixel_index;
      dx12 <= sx(vert2_x) - sx(vert1_x);
      dy12 <= sx(vert2_y) - sx(vert1_y);
      dx20 <= sx(vert0_x) - sx(vert2_x);
      dy20 <= sx(vert0_y) - sx(vert2_y);
      dx01 <= sx(vert1_x) - sx(vert0_x);
      dy01 <= sx(vert1_y) - sx(vert0_y);
      count <= '0;
    end
    if (state == S_SETUP || state == S_PIX) begin
      if (step == STEP_W0) w0 <= W_W'(acc);
      if (step == STEP_W1) w1 <= W_W'(acc);
      if (step == STEP_W2) w2 <= W_W'(acc);
    end
    if (state == S_SETUP && step == STEP_W2) area <= W_W'(acc);
    if (state == S_BOX) begin
      bx0      <= bx0_c;
      bx1      <= bx1_c;
      by1      <= by1_c;
      px       <= bx0_c;
      py       <= by0_c;
      row_base <= ADDR_W'(by0_c * EXTENT);
    end
    if ((state == S_PIX && step == STEP_SUM && !covered) || state == S_WRITE) begin
      if (last_px) begin
        px       <= bx0;
        py       <= py + 1'b1;
        row_base <= row_base + ADDR_W'(EXTENT);
      end else begin
        px <= px + 1'b1;
      end
    end
    if (state == S_WRITE && wr.en && count != COUNT_MAX) count <= count + 1'b1;
  end

  trd_mac u_mac (
    .clk (clk),
    .rst (rst),
    .req (mac_req),
    .acc (acc)
  );

  trd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (acc),
    .den   (area),
    .done  (div_done),
    .quot  (z)
  );

  trd_frame u_frame (
    .clk    (clk),
    .wr     (wr),
    .raddr  (raddr),
    .rdepth (rdepth),
    .rcolor (rcolor)
  );

endmodule

>>> design/trd_checker.sv
// Port-level checker for the rasterizer and its bind.
`timescale 1ns / 1ps
`include "triangle_raster_depth_test_defines.svh"
module trd_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic                                done,
  input logic [1:0]                          cmd,
  input logic [trd_pkg::COLOR_W-1:0]         pixel_color,
  input logic signed [trd_pkg::DEPTH_W-1:0]  pixel_depth,
  input logic [trd_pkg::COUNT_W-1:0]         written_count,
  input logic                                degenerate
);
  import trd_pkg::*;

  // clearing pass follows reset
  `TRD_ASSERT_RST_NEXT(a_reset_clears, rst, busy)
  // a clear beat always sweeps the stores
  `TRD_ASSERT_NEXT(a_clear_busy, start && !busy && cmd == CMD_CLEAR, busy)
  // skipped draw writes nothing
  `TRD_ASSERT_NOW(a_degen_count, done && degenerate, written_count == '0)
  // pixel data only comes back from a read
  `TRD_ASSERT_NOW(a_read_only, done && (pixel_color != '0 || pixel_depth != '0),
                  written_count == '0 && !degenerate)

endmodule

bind triangle_raster_depth_test trd_checker u_trd_checker (.*);
